// File: rtl/chacha_pkg.sv
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types and constants for the ChaCha byte-stream cipher: the controller
// command and status groups, controller states, register indexes and the
// expansion constants.
// ----------------------------------------------------------------------------
package chacha_pkg;

   typedef logic [15:0][31:0]     words_type;
   typedef logic [15:0][3:0][7:0] ks_type;

   // "expand 32-byte k" and "expand 16-byte k", word 0 first
   localparam logic [3:0][31:0] SIGMA32 = {32'h6b206574, 32'h79622d32,
                                           32'h3320646e, 32'h61707865};
   localparam logic [3:0][31:0] SIGMA16 = {32'h6b206574, 32'h79622d36,
                                           32'h3120646e, 32'h61707865};

   // configuration register indexes
   localparam logic [2:0] CSR_KEY_01    = 3'd0;
   localparam logic [2:0] CSR_KEY_23    = 3'd1;
   localparam logic [2:0] CSR_KEY_45    = 3'd2;
   localparam logic [2:0] CSR_KEY_67    = 3'd3;
   localparam logic [2:0] CSR_NONCE     = 3'd4;
   localparam logic [2:0] CSR_SHORT_KEY = 3'd5;
   localparam logic [2:0] CSR_ROUNDS    = 3'd6;
   localparam logic [2:0] CSR_START_CTR = 3'd7;

   // round mode codes
   localparam logic [1:0] RM_20 = 2'd0;
   localparam logic [1:0] RM_12 = 2'd1;
   localparam logic [1:0] RM_8  = 2'd2;

   localparam logic [4:0] ROUNDS_20 = 5'd20;
   localparam logic [4:0] ROUNDS_12 = 5'd12;
   localparam logic [4:0] ROUNDS_8  = 5'd8;

   localparam logic [5:0] LAST_POS = 6'd63;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FEED  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;
      logic round;
      logic diag;
      logic feed;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic       need_block;
      logic       out_free;
      logic [4:0] round_total;
   } status_type;

endpackage

// File: rtl/chacha_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha_stream_cipher - ChaCha byte-stream cipher, 64-bit nonce and counter
// Each accepted byte goes through the emit state into the output register; the
// first byte of each 64-byte block, and of each message, first runs the rounds
// (20, 12 or 8) and the feed-forward, one full round per cycle in the
// quarter-round unit. A new byte is taken only once the last has been emitted.
// Reset (synchronous, active high) clears registers, counter and position.
// ----------------------------------------------------------------------------
module chacha_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_msg_start,
   input  logic        req_msg_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last
);

   import chacha_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   chacha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   chacha_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_data_byte (req_data_byte),
      .req_msg_start (req_msg_start),
      .req_msg_last  (req_msg_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

// File: rtl/chacha_qr.sv
// ----------------------------------------------------------------------------
// chacha_qr
// One ChaCha quarter round on four 32-bit words, roles a, b, c, d.
// ----------------------------------------------------------------------------
module chacha_qr (
   input  logic [3:0][31:0] q_in,
   output logic [3:0][31:0] q_out
);

   logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2, t0, t1, t2, t3;

   always_comb begin
      a1 = q_in[0] + q_in[1];
      t0 = q_in[3] ^ a1;
      d1 = {t0[15:0], t0[31:16]};
      c1 = q_in[2] + d1;
      t1 = q_in[1] ^ c1;
      b1 = {t1[19:0], t1[31:20]};
      a2 = a1 + b1;
      t2 = d1 ^ a2;
      d2 = {t2[23:0], t2[31:24]};
      c2 = c1 + d2;
      t3 = b1 ^ c2;
      b2 = {t3[24:0], t3[31:25]};
      q_out = {d2, c2, b2, a2};
   end

endmodule

// File: rtl/chacha_ctrl.sv
// ----------------------------------------------------------------------------
// chacha_ctrl
// Sequencer: takes a byte, runs the rounds and feed-forward when a fresh
// keystream block is needed, then hands the result to the output register.
// ----------------------------------------------------------------------------
module chacha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  chacha_pkg::status_type status,
   output chacha_pkg::cmd_type    cmd
);

   import chacha_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] rnd_ff, rnd_in;
   logic       last_round;

   assign req_stall  = (state_ff != ST_IDLE);
   assign last_round = (rnd_ff == status.round_total - 5'd1);

   always_comb begin
      state_in   = state_ff;
      rnd_in     = rnd_ff;
      cmd        = '0;
      cmd.diag   = rnd_ff[0];
      case (state_ff)
         ST_IDLE: begin
            rnd_in = '0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.need_block ? ST_ROUND : ST_EMIT;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 5'd1;
            if (last_round) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            cmd.feed = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the byte
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
      end
   end

endmodule

// File: rtl/chacha_dp.sv
// ----------------------------------------------------------------------------
// chacha_dp
// Datapath: configuration registers, block counter, byte position, working
// state with four quarter-round lanes, keystream buffer and output register.
// ----------------------------------------------------------------------------
module chacha_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  chacha_pkg::cmd_type    cmd,
   output chacha_pkg::status_type status,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_data,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_msg_start,
   input  logic                   req_msg_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);

   import chacha_pkg::*;

   logic [63:0] key01_ff, key23_ff, key45_ff, key67_ff, nonce_ff, start_ctr_ff;
   logic        short_key_ff;
   logic [1:0]  round_mode_ff;

   logic [63:0] counter_ff;
   logic [5:0]  pos_ff;
   logic        ks_valid_ff;
   words_type   work_ff;
   ks_type      ks_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   logic [63:0]            ctr_sel;
   words_type              init_words;
   words_type              round_nxt;
   logic [3:0][3:0][31:0]  qr_in;
   logic [3:0][3:0][31:0]  qr_out;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff      <= '0;
         key23_ff      <= '0;
         key45_ff      <= '0;
         key67_ff      <= '0;
         nonce_ff      <= '0;
         short_key_ff  <= 1'b0;
         round_mode_ff <= RM_20;
         start_ctr_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_01:    key01_ff      <= csr_data;
            CSR_KEY_23:    key23_ff      <= csr_data;
            CSR_KEY_45:    key45_ff      <= csr_data;
            CSR_KEY_67:    key67_ff      <= csr_data;
            CSR_NONCE:     nonce_ff      <= csr_data;
            CSR_SHORT_KEY: short_key_ff  <= csr_data[0];
            CSR_ROUNDS:    round_mode_ff <= csr_data[1:0];
            CSR_START_CTR: start_ctr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      status.need_block = req_msg_start || !ks_valid_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      case (round_mode_ff)
         RM_20:   status.round_total = ROUNDS_20;
         RM_12:   status.round_total = ROUNDS_12;
         default: status.round_total = ROUNDS_8;
      endcase
   end

   // ---- input block: on a message start the start counter feeds the block this cycle ----
   assign ctr_sel = (cmd.accept && req_msg_start) ? start_ctr_ff : counter_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_words[i] = short_key_ff ? SIGMA16[i] : SIGMA32[i];
      end
      init_words[4]  = key01_ff[31:0];
      init_words[5]  = key01_ff[63:32];
      init_words[6]  = key23_ff[31:0];
      init_words[7]  = key23_ff[63:32];
      init_words[8]  = short_key_ff ? key01_ff[31:0]  : key45_ff[31:0];
      init_words[9]  = short_key_ff ? key01_ff[63:32] : key45_ff[63:32];
      init_words[10] = short_key_ff ? key23_ff[31:0]  : key67_ff[31:0];
      init_words[11] = short_key_ff ? key23_ff[63:32] : key67_ff[63:32];
      init_words[12] = ctr_sel[31:0];
      init_words[13] = ctr_sel[63:32];
      init_words[14] = nonce_ff[31:0];
      init_words[15] = nonce_ff[63:32];
   end

   // ---- round unit: lane l takes role r from a column or a diagonal ----
   for (genvar r = 0; r < 4; r++) begin : g_role
      for (genvar l = 0; l < 4; l++) begin : g_lane
         localparam int COL_IDX = 4 * r + l;
         localparam int DIA_IDX = 4 * r + (l + r) % 4;
         assign qr_in[l][r] = cmd.diag ? work_ff[DIA_IDX] : work_ff[COL_IDX];
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_qr
      chacha_qr u_qr (
         .q_in  (qr_in[l]),
         .q_out (qr_out[l])
      );
   end

   for (genvar w = 0; w < 16; w++) begin : g_word
      localparam int ROLE     = w / 4;
      localparam int COL_LANE = w % 4;
      localparam int DIA_LANE = (w % 4 - ROLE + 4) % 4;
      assign round_nxt[w] = cmd.diag ? qr_out[DIA_LANE][ROLE] : qr_out[COL_LANE][ROLE];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         work_ff <= init_words;
      end else if (cmd.round) begin
         work_ff <= round_nxt;
      end
   end

   // ---- feed-forward into the keystream buffer ----
   always_ff @(posedge clock) begin
      if (cmd.feed) begin
         for (int i = 0; i < 16; i++) begin
            ks_ff[i] <= work_ff[i] + init_words[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_msg_last;
      end
   end

   // ---- counter, position and buffer flag ----
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         pos_ff      <= '0;
         ks_valid_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (req_msg_start) begin
            counter_ff  <= start_ctr_ff;
            pos_ff      <= '0;
            ks_valid_ff <= 1'b0;
         end
      end else if (cmd.feed) begin
         ks_valid_ff <= 1'b1;
      end else if (cmd.emit) begin
         pos_ff <= pos_ff + 6'd1;
         if (pos_ff == LAST_POS) begin
            // advance to the next block
            counter_ff  <= counter_ff + 64'd1;
            ks_valid_ff <= 1'b0;
         end
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= data_ff ^ ks_ff[pos_ff[5:2]][pos_ff[1:0]];
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule
